### src/i2crs_pkg.sv
// Shared types and constants of the I2C register transaction sequencer.
package i2crs_pkg;

    localparam int CNT_W      = 6;
    localparam int IDX_W      = 5;
    localparam int ADDR_MAX_W = 8;
    localparam int CMP_W      = 9;

    typedef enum logic [2:0] {
        OP_START_READ  = 3'd0,
        OP_START_WRITE = 3'd1,
        OP_LOAD_BYTE   = 3'd2,
        OP_TX_READY    = 3'd3,
        OP_RX_BYTE     = 3'd4,
        OP_READ_BUF    = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_REG   = 3'd1,
        PH_TURN  = 3'd2,
        PH_WRITE = 3'd3,
        PH_READ  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [2:0]       op;
        logic [6:0]       dev_address;
        logic [7:0]       register_address;
        logic [CNT_W-1:0] byte_count;
        logic [IDX_W-1:0] buffer_index;
        logic [7:0]       data_byte;
    } t_in;

    typedef struct packed {
        logic       start_cond;
        logic       transmit_dir;
        logic       stop_cond;
        logic       stop_after_start;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       tx_event_enable;
        logic       rx_event_enable;
        logic [6:0] slave_address;
        logic [2:0] phase;
        logic       done_res;
        logic [7:0] read_data;
    } t_out;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] wr_addr;
        logic [7:0]            wr_data;
        logic                  rd_en;
        logic [ADDR_MAX_W-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        t_out res;
        logic sel_tx;
        logic sel_rx;
    } t_stage;

endpackage

### src/i2crs_store.sv
// Byte buffer memory with one write port, one registered read port and per-entry valid bits.
module i2crs_store
    import i2crs_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rdata;
    logic [ADDR_W-1:0] wr_a;
    logic [ADDR_W-1:0] rd_a;

    assign wr_a = i_req.wr_addr[ADDR_W-1:0];
    assign rd_a = i_req.rd_addr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[wr_a] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[wr_a] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_valid[rd_a] ? r_mem[rd_a] : 8'd0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/i2crs_seq.sv
// Transaction sequencer state machine that updates the control state and drives the buffers.
module i2crs_seq
    import i2crs_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in      i_item,
    output t_stage   o_stage,
    output t_mem_req o_tx_req,
    output t_mem_req o_rx_req
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    t_phase            r_phase, n_phase;
    logic [7:0]        r_reg_addr, n_reg_addr;
    logic [6:0]        r_slave_addr, n_slave_addr;
    logic [CNT_W-1:0]  r_rx_rem, n_rx_rem;
    logic [CNT_W-1:0]  r_tx_rem, n_tx_rem;
    logic [ADDR_W-1:0] r_rx_ptr, n_rx_ptr;
    logic [ADDR_W-1:0] r_tx_ptr, n_tx_ptr;
    logic              r_tx_irq, n_tx_irq;
    logic              r_rx_irq, n_rx_irq;
    logic              r_dir, n_dir;
    t_stage            r_stage, n_stage;

    logic             idx_ok;
    logic [CNT_W-1:0] cnt_sat;
    logic [CNT_W-1:0] rx_rem_ev;

    assign idx_ok  = {4'd0, i_item.buffer_index} < CMP_W'(BUFFER_DEPTH);
    assign cnt_sat = ({3'd0, i_item.byte_count} > CMP_W'(BUFFER_DEPTH)) ?
                     CNT_W'(BUFFER_DEPTH) : i_item.byte_count;
    assign rx_rem_ev = (r_rx_rem != '0) ? (r_rx_rem - CNT_W'(1)) : '0;

    always_comb begin
        n_phase = r_phase;
        unique case (i_item.op) inside
            OP_START_READ, OP_START_WRITE: begin
                n_phase = PH_REG;
            end
            OP_TX_READY: begin
                if (r_tx_irq) begin
                    unique case (r_phase)
                        PH_REG:   n_phase = (r_rx_rem != '0) ? PH_TURN : PH_WRITE;
                        PH_TURN:  n_phase = PH_READ;
                        PH_WRITE: n_phase = (r_tx_rem == '0) ? PH_IDLE : PH_WRITE;
                        PH_IDLE, PH_READ: n_phase = r_phase;
                        default:  n_phase = r_phase;
                    endcase
                end
            end
            OP_RX_BYTE: begin
                if (r_rx_irq && rx_rem_ev == '0) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = r_phase;
        endcase
    end

    always_comb begin
        n_reg_addr   = r_reg_addr;
        n_slave_addr = r_slave_addr;
        n_rx_rem     = r_rx_rem;
        n_tx_rem     = r_tx_rem;
        n_rx_ptr     = r_rx_ptr;
        n_tx_ptr     = r_tx_ptr;
        n_tx_irq     = r_tx_irq;
        n_rx_irq     = r_rx_irq;
        n_dir        = r_dir;
        n_stage      = '0;
        o_tx_req     = '0;
        o_rx_req     = '0;
        unique case (i_item.op) inside
            OP_START_READ, OP_START_WRITE: begin
                n_reg_addr   = i_item.register_address;
                n_slave_addr = i_item.dev_address;
                n_rx_rem     = (i_item.op == OP_START_READ) ? cnt_sat : '0;
                n_tx_rem     = (i_item.op == OP_START_READ) ? '0 : cnt_sat;
                n_rx_ptr     = '0;
                n_tx_ptr     = '0;
                n_rx_irq     = 1'b0;
                n_tx_irq     = 1'b1;
                n_dir        = 1'b1;
                n_stage.res.start_cond = 1'b1;
            end
            OP_LOAD_BYTE: begin
                o_tx_req.wr_en   = i_accept && idx_ok;
                o_tx_req.wr_addr = ADDR_MAX_W'(i_item.buffer_index);
                o_tx_req.wr_data = i_item.data_byte;
            end
            OP_TX_READY: begin
                if (r_tx_irq) begin
                    unique case (r_phase)
                        PH_REG: begin
                            n_stage.res.send_valid = 1'b1;
                            n_stage.res.send_byte  = r_reg_addr;
                        end
                        PH_TURN: begin
                            n_rx_irq = 1'b1;
                            n_tx_irq = 1'b0;
                            n_dir    = 1'b0;
                            n_stage.res.start_cond       = 1'b1;
                            n_stage.res.stop_after_start = (r_rx_rem == CNT_W'(1));
                        end
                        PH_WRITE: begin
                            if (r_tx_rem != '0) begin
                                n_stage.res.send_valid = 1'b1;
                                n_stage.sel_tx         = 1'b1;
                                o_tx_req.rd_en         = i_accept;
                                o_tx_req.rd_addr       = ADDR_MAX_W'(r_tx_ptr);
                                n_tx_ptr = r_tx_ptr + ADDR_W'(1);
                                n_tx_rem = r_tx_rem - CNT_W'(1);
                            end else begin
                                n_stage.res.stop_cond = 1'b1;
                                n_stage.res.done_res  = 1'b1;
                                n_tx_irq = 1'b0;
                            end
                        end
                        PH_IDLE, PH_READ: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_RX_BYTE: begin
                if (r_rx_irq) begin
                    if (r_rx_rem != '0) begin
                        o_rx_req.wr_en   = i_accept;
                        o_rx_req.wr_addr = ADDR_MAX_W'(r_rx_ptr);
                        o_rx_req.wr_data = i_item.data_byte;
                        n_rx_ptr = r_rx_ptr + ADDR_W'(1);
                        n_stage.res.read_data = i_item.data_byte;
                    end
                    n_rx_rem = rx_rem_ev;
                    if (rx_rem_ev == CNT_W'(1)) begin
                        n_stage.res.stop_cond = 1'b1;
                    end else if (rx_rem_ev == '0) begin
                        n_rx_irq = 1'b0;
                        n_stage.res.done_res = 1'b1;
                    end
                end
            end
            OP_READ_BUF: begin
                if (idx_ok) begin
                    n_stage.sel_rx   = 1'b1;
                    o_rx_req.rd_en   = i_accept;
                    o_rx_req.rd_addr = ADDR_MAX_W'(i_item.buffer_index);
                end
            end
            default: begin
            end
        endcase
        n_stage.res.transmit_dir    = n_dir;
        n_stage.res.tx_event_enable = n_tx_irq;
        n_stage.res.rx_event_enable = n_rx_irq;
        n_stage.res.slave_address   = n_slave_addr;
        n_stage.res.phase           = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_reg_addr   <= '0;
            r_slave_addr <= '0;
            r_rx_rem     <= '0;
            r_tx_rem     <= '0;
            r_rx_ptr     <= '0;
            r_tx_ptr     <= '0;
            r_tx_irq     <= 1'b0;
            r_rx_irq     <= 1'b0;
            r_dir        <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_reg_addr   <= n_reg_addr;
            r_slave_addr <= n_slave_addr;
            r_rx_rem     <= n_rx_rem;
            r_tx_rem     <= n_tx_rem;
            r_rx_ptr     <= n_rx_ptr;
            r_tx_ptr     <= n_tx_ptr;
            r_tx_irq     <= n_tx_irq;
            r_rx_irq     <= n_rx_irq;
            r_dir        <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

### src/i2crs_ofifo.sv
// Two-entry result queue that parts the sequencer from the result receiver.
module i2crs_ofifo
    import i2crs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_data,
    output logic o_room,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_out       r_data [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_data  = r_data[r_rptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

### src/i2c_register_transaction_sequencer_unit.sv
// Top level of the I2C register transaction sequencer.
//
// Items arrive on the input channel (i_in_valid, o_in_ready, i_in_data) and each
// one gives exactly one result on the output channel (o_out_valid, i_out_ready,
// o_out_data), in order. A transfer happens at a rising edge with valid and
// ready both high.
// Throughput is one item per cycle unless the receiver stalls and the queue fills.
// When an item is taken, the control state is updated and the buffer access is
// issued into the stage register; from there the result, with the registered
// buffer read, moves into the two-entry result queue and becomes visible.
// When the receiver stalls, the queue absorbs results; input is still taken
// while one result waits, and o_in_ready falls only once the queue is full
// and the stage in front of it is occupied.
// Reset is synchronous and active low. It returns the sequencer to idle and
// clears the buffer valid bits at once, so both buffers read as zero without
// any clearing pass.
module i2c_register_transaction_sequencer_unit
    import i2crs_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic       r_s1_valid, n_s1_valid;
    logic       accept;
    logic       s1_move;
    logic       room;
    t_stage     stage;
    t_mem_req   tx_req;
    t_mem_req   rx_req;
    logic [7:0] tx_rdata;
    logic [7:0] rx_rdata;
    t_out       result;

    assign s1_move    = r_s1_valid && room;
    assign o_in_ready = !r_s1_valid || room;
    assign accept     = i_in_valid && o_in_ready;
    assign n_s1_valid = accept || (r_s1_valid && !s1_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    i2crs_seq #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_stage  (stage),
        .o_tx_req (tx_req),
        .o_rx_req (rx_req)
    );

    i2crs_store #(
        .DEPTH(BUFFER_DEPTH)
    ) u_tx_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tx_req),
        .o_rdata (tx_rdata)
    );

    i2crs_store #(
        .DEPTH(BUFFER_DEPTH)
    ) u_rx_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rx_req),
        .o_rdata (rx_rdata)
    );

    always_comb begin
        result = stage.res;
        if (stage.sel_tx) begin
            result.send_byte = tx_rdata;
        end
        if (stage.sel_rx) begin
            result.read_data = rx_rdata;
        end
    end

    i2crs_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_move),
        .i_data  (result),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

### src/i2crs_checker.sv
// Port-level checks of the I2C register transaction sequencer and their binding.
module i2crs_checker
    import i2crs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result changed or vanished.");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("Input refused with no result waiting.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |->
        o_out_data.phase == PH_IDLE && !o_out_data.tx_event_enable &&
        !o_out_data.rx_event_enable)
        else $error("Finished transfer left the sequencer busy.");

    a_send_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.send_valid |->
        (o_out_data.phase == PH_TURN || o_out_data.phase == PH_WRITE) &&
        o_out_data.tx_event_enable)
        else $error("Byte sent outside a transmit phase.");

    a_stop_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stop_after_start |->
        o_out_data.start_cond && o_out_data.phase == PH_READ && !o_out_data.transmit_dir)
        else $error("Stop after start requested outside the turn to read.");

endmodule

bind i2c_register_transaction_sequencer_unit i2crs_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
